// ===== hdl/bal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_pkg - shared types for the bounded array list
// Request kinds, result status codes and the per-cell control word.
// ----------------------------------------------------------------------------
package bal_pkg;

  // Request kinds as they arrive on kind_i
  typedef enum logic [2:0] {
    KIND_ADD_FRONT = 3'd0,
    KIND_ADD_BACK  = 3'd1,
    KIND_REM_FRONT = 3'd2,
    KIND_REM_BACK  = 3'd3,
    KIND_READ      = 3'd4,
    KIND_WRITE     = 3'd5
  } kind_e;

  // Result status
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Control word broadcast to every cell of the row
  typedef struct packed {
    logic shift_up;    // take the left neighbour's word
    logic shift_down;  // take the right neighbour's word
    logic load;        // cell at the load index takes the new word
  } cell_ctrl_t;

  // Request width constants fixed by the interface
  localparam int unsigned KindW  = 3;
  localparam int unsigned WordW  = 32;
  localparam int unsigned StatW  = 2;

endpackage

// ===== hdl/bal_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_cell - one storage cell of the list row
// Holds one element; loads, shifts up or shifts down on command.
// ----------------------------------------------------------------------------
module bal_cell #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  bal_pkg::cell_ctrl_t   ctrl_i,
  input  logic [IDX_W-1:0]      load_idx_i,
  input  logic [DATA_WIDTH-1:0] new_word_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] word_o
);
  import bal_pkg::*;

  logic [DATA_WIDTH-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (ctrl_i.load && (load_idx_i == IDX_W'(INDEX))) begin
      word_d = new_word_i;
    end else if (ctrl_i.shift_up) begin
      word_d = left_i;
    end else if (ctrl_i.shift_down) begin
      word_d = right_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== hdl/bal_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bal_ctrl - request decode and element count
// Decodes a request, clamps its index, keeps the count, drives the cells.
// ----------------------------------------------------------------------------
module bal_ctrl #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IDX_W = 4,
  parameter int unsigned CNT_W = 5
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       fire_i,
  input  logic [bal_pkg::KindW-1:0]  kind_i,
  input  logic signed [bal_pkg::WordW-1:0] index_i,
  output bal_pkg::cell_ctrl_t        cell_ctrl_o,
  output logic [IDX_W-1:0]           idx_o,
  output logic                       rd_en_o,
  output logic [bal_pkg::StatW-1:0]  status_o,
  output logic [CNT_W-1:0]           cnt_o,
  output logic [CNT_W-1:0]           cnt_next_o
);
  import bal_pkg::*;

  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_m1;
  logic             full, empty;
  logic [IDX_W-1:0] pos;
  cell_ctrl_t       ctrl;

  assign full   = (cnt_q == CNT_W'(DEPTH));
  assign empty  = (cnt_q == '0);
  assign cnt_m1 = cnt_q - CNT_W'(1);

  // clamp index into 0 .. count-1
  always_comb begin
    if (index_i[WordW-1]) begin
      pos = '0;
    end else if (unsigned'(index_i) >= WordW'(cnt_q)) begin
      pos = cnt_m1[IDX_W-1:0];
    end else begin
      pos = index_i[IDX_W-1:0];
    end
  end

  always_comb begin
    ctrl     = '0;
    idx_o    = pos;
    rd_en_o  = 1'b0;
    status_o = ST_DONE;
    cnt_d    = cnt_q;
    case (kind_i)
      KIND_ADD_FRONT: begin
        if (full) begin
          status_o = ST_FULL;
        end else begin
          ctrl.shift_up = 1'b1;
          cnt_d         = cnt_q + CNT_W'(1);
        end
      end
      KIND_ADD_BACK: begin
        idx_o = cnt_q[IDX_W-1:0];
        if (full) begin
          status_o = ST_FULL;
        end else begin
          ctrl.load = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
        end
      end
      KIND_REM_FRONT: begin
        if (empty) begin
          status_o = ST_EMPTY;
        end else begin
          ctrl.shift_down = 1'b1;
          cnt_d           = cnt_m1;
        end
      end
      KIND_REM_BACK: begin
        if (empty) begin
          status_o = ST_EMPTY;
        end else begin
          cnt_d = cnt_m1;
        end
      end
      KIND_READ: begin
        if (empty) begin
          status_o = ST_EMPTY;
        end else begin
          rd_en_o = 1'b1;
        end
      end
      KIND_WRITE: begin
        if (empty) begin
          status_o = ST_EMPTY;
        end else begin
          ctrl.load = 1'b1;
        end
      end
      default: begin
        // unused codes: no change, done
      end
    endcase
  end

  // drop cell commands unless a request is taken this cycle
  assign cell_ctrl_o = fire_i ? ctrl : '0;
  assign cnt_o       = cnt_q;
  assign cnt_next_o  = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (fire_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hdl/bounded_array_list_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_top - fixed-capacity double-ended array list
// Row of storage cells with front/back insert and remove, indexed access.
// ----------------------------------------------------------------------------
// The list takes one request per clock cycle and returns one result per
// request, in the cycle after acceptance, from an output register. Every
// operation, including an insert or remove at the front, finishes in the
// cycle of acceptance: the elements live in a row of DEPTH cells that all
// shift up or down together, so a new request may follow at once and is
// held off only while a finished result waits for out_ready_i. Reads and
// writes clamp the index into 0 .. count-1; inserting when full returns
// the full status, removing, reading or writing when empty returns the
// empty status, and neither changes the list. Cell contents are not
// cleared at reset; only positions below the count are ever read.
// ----------------------------------------------------------------------------
module bounded_array_list_top #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [bal_pkg::KindW-1:0]           kind_i,
  input  logic signed [bal_pkg::WordW-1:0]    value_i,
  input  logic signed [bal_pkg::WordW-1:0]    index_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [bal_pkg::WordW-1:0]    read_value_o,
  output logic [bal_pkg::StatW-1:0]           status_o,
  output logic [CNT_W-1:0]                    count_o
);
  import bal_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic                  fire;
  cell_ctrl_t            cell_ctrl;
  logic [IdxW-1:0]       idx;
  logic                  rd_en;
  logic [StatW-1:0]      status;
  logic [CNT_W-1:0]      cnt_cur, cnt_next;
  logic [63:0]           value_wide;
  logic [DATA_WIDTH-1:0] new_word;
  logic [DATA_WIDTH-1:0] cell_word [DEPTH];
  logic [DATA_WIDTH-1:0] rd_word;
  logic signed [63:0]    rd_ext;
  logic [WordW-1:0]      rd_value;

  logic                  out_valid_q;
  logic [WordW-1:0]      read_value_q;
  logic [StatW-1:0]      status_q;
  logic [CNT_W-1:0]      count_q;

  // accept whenever the output register is free or being emptied
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // keep the low DATA_WIDTH bits of the request value, zero above bit 31
  assign value_wide = {32'b0, value_i};
  assign new_word   = value_wide[DATA_WIDTH-1:0];

  bal_ctrl #(
    .DEPTH (DEPTH),
    .IDX_W (IdxW),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .kind_i      (kind_i),
    .index_i     (index_i),
    .cell_ctrl_o (cell_ctrl),
    .idx_o       (idx),
    .rd_en_o     (rd_en),
    .status_o    (status),
    .cnt_o       (cnt_cur),
    .cnt_next_o  (cnt_next)
  );

  // Row of cells: cell 0 takes the new word on a front insert, the last
  // cell takes zero on a front remove (that slot falls outside the count).
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = new_word;
    end else begin : g_left
      assign left_w = cell_word[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_word[g+1];
    end
    bal_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IdxW),
      .INDEX      (g)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .load_idx_i (idx),
      .new_word_i (new_word),
      .left_i     (left_w),
      .right_i    (right_w),
      .word_o     (cell_word[g])
    );
  end

  // select the addressed cell: AND each word with its decode, OR together
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | (cell_word[i] & {DATA_WIDTH{idx == IdxW'(i)}});
    end
  end

  // sign-extend from DATA_WIDTH, hand over the low 32 bits
  assign rd_ext   = 64'(signed'(rd_word));
  assign rd_value = rd_en ? rd_ext[WordW-1:0] : '0;

  // result register: advance on accept, hold while stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      read_value_q <= rd_value;
      status_q     <= status;
      count_q      <= cnt_next;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = signed'(read_value_q);
  assign status_o     = status_q;
  assign count_o      = count_q;

  // count never passes capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_cur <= CNT_W'(DEPTH))
    else $error("element count beyond capacity");

  // an insert into a full list is rejected and leaves the count alone
  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && cnt_cur == CNT_W'(DEPTH) &&
     (kind_i == KIND_ADD_FRONT || kind_i == KIND_ADD_BACK))
    |=> (status_o == ST_FULL && count_o == $past(cnt_cur)))
    else $error("insert when full not rejected");

  // anything but a successful read returns a zero word
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !rd_en) |=> (read_value_o == '0 && out_valid_o))
    else $error("non-read result carries data");

endmodule
